[rtl/mrd_pkg.sv]
// Shared types and constants for the MIDI short-message decoder.
// Holds event codes, status nibbles, controller numbers and state/result structs.
// No dependencies.
package mrd_pkg;

    localparam int unsigned NUM_CHANNELS = 16;

    typedef enum logic [3:0] {
        EV_NOTE       = 4'd0,
        EV_POLY       = 4'd1,
        EV_CC         = 4'd2,
        EV_PROGRAM    = 4'd3,
        EV_AFTERTOUCH = 4'd4,
        EV_PITCH      = 4'd5,
        EV_SYSTEM     = 4'd6,
        EV_RPN        = 4'd7,
        EV_NRPN       = 4'd8
    } event_kind_t;

    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY       = 4'hA;
    localparam logic [3:0] ST_CC         = 4'hB;
    localparam logic [3:0] ST_PROGRAM    = 4'hC;
    localparam logic [3:0] ST_AFTERTOUCH = 4'hD;
    localparam logic [3:0] ST_PITCH      = 4'hE;

    localparam logic [6:0] CC_RPN_MSB   = 7'd101;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
    localparam logic [6:0] CC_DATA_MSB  = 7'd6;
    localparam logic [6:0] CC_DATA_LSB  = 7'd38;
    localparam logic [6:0] NULL_PARAM   = 7'd127;

    localparam int unsigned FLAG_NRPN = 0;
    localparam int unsigned FLAG_PLO  = 1;
    localparam int unsigned FLAG_PHI  = 2;
    localparam int unsigned FLAG_VHI  = 3;

    typedef struct packed {
        logic [3:0]  flags;
        logic [13:0] number;
        logic [13:0] value;
    } chan_state_t;

    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  channel;
        logic [13:0] control;
        logic [13:0] value;
        logic        last;
    } result_t;

endpackage

[rtl/midi_input_decoder_with_rpn_nrpn_top.sv]
// MIDI short-message decoder with per-channel RPN/NRPN tracking, top level.
// An accepted message is held in the input register, decoded, and written into the result queue.
// Throughput: one item per cycle while the queue has room for two results; an item with a parameter result yields two.
// The rate is set by the four-entry result queue draining one result per cycle while m_ready is high.
// Reset (aresetn, synchronous, active low) clears all channel state and empties the queue.
// Depends on mrd_pkg and mrd_decode.
module midi_input_decoder_with_rpn_nrpn_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_msg_kind,
    input  logic [7:0]  s_status_byte,
    input  logic [6:0]  s_data_first,
    input  logic [6:0]  s_data_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [3:0]  m_midi_channel,
    output logic [13:0] m_control_number,
    output logic [13:0] m_raw_value,
    output logic        m_last_of_run
);
    import mrd_pkg::*;

    logic        in_valid_reg;
    logic        in_msg_kind_reg;
    logic [7:0]  in_status_reg;
    logic [6:0]  in_data_first_reg;
    logic [6:0]  in_data_second_reg;

    chan_state_t state_reg [NUM_CHANNELS];
    chan_state_t state_next;

    result_t     q_reg [4];
    logic [1:0]  wp_reg;
    logic [1:0]  rp_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;

    logic [1:0]  num_results;
    logic [1:0]  push_cnt;
    result_t     res_first;
    result_t     res_second;
    result_t     head;
    logic        fire;
    logic        pop;
    logic [3:0]  ch;

    assign ch      = in_status_reg[3:0];
    assign fire    = in_valid_reg && (count_reg <= 3'd2);
    assign s_ready = !in_valid_reg || fire;
    assign pop     = m_valid && m_ready;
    assign push_cnt = fire ? num_results : 2'd0;
    assign count_next = count_reg + {1'b0, push_cnt} - {2'b00, pop};

    mrd_decode u_decode (
        .msg_kind    (in_msg_kind_reg),
        .status_byte (in_status_reg),
        .data_first  (in_data_first_reg),
        .data_second (in_data_second_reg),
        .state_in    (state_reg[ch]),
        .state_out   (state_next),
        .num_results (num_results),
        .res_first   (res_first),
        .res_second  (res_second)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_msg_kind_reg    <= s_msg_kind;
            in_status_reg      <= s_status_byte;
            in_data_first_reg  <= s_data_first;
            in_data_second_reg <= s_data_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (fire) begin
            state_reg[ch] <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= 2'd0;
            rp_reg    <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            wp_reg    <= wp_reg + push_cnt;
            rp_reg    <= rp_reg + {1'b0, pop};
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wp_reg] <= res_first;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wp_reg + 2'd1] <= res_second;
        end
    end

    assign head             = q_reg[rp_reg];
    assign m_valid          = (count_reg != 3'd0);
    assign m_event_kind     = head.kind;
    assign m_midi_channel   = head.channel;
    assign m_control_number = head.control;
    assign m_raw_value      = head.value;
    assign m_last_of_run    = head.last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue count out of range");

    a_param_followed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> (count_reg >= 3'd2))
        else $error("parameter result queued without its plain result");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_status_reg)
            && $stable(in_data_first_reg) && $stable(in_data_second_reg)))
        else $error("stalled input register changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (count_reg == 3'd0 && !in_valid_reg))
        else $error("reset did not empty the datapath");
`endif

endmodule

[rtl/mrd_decode.sv]
// Combinational decode of one MIDI short message with RPN/NRPN tracking.
// Produces the updated channel state and up to two result items.
// Depends on mrd_pkg.
module mrd_decode (
    input  logic                msg_kind,
    input  logic [7:0]          status_byte,
    input  logic [6:0]          data_first,
    input  logic [6:0]          data_second,
    input  mrd_pkg::chan_state_t state_in,
    output mrd_pkg::chan_state_t state_out,
    output logic [1:0]          num_results,
    output mrd_pkg::result_t    res_first,
    output mrd_pkg::result_t    res_second
);
    import mrd_pkg::*;

    event_kind_t kind;
    logic [13:0] ctl;
    logic [13:0] val;
    logic [3:0]  f;
    logic [13:0] num;
    logic [13:0] pv;
    logic        track;
    logic        done;
    logic        skip;
    logic        is_addr;
    result_t     plain;

    always_comb begin
        kind = EV_SYSTEM;
        ctl  = {7'd0, data_first};
        val  = {7'd0, data_second};
        case (status_byte[7:4])
            ST_NOTE_OFF: begin
                kind = EV_NOTE;
                val  = 14'd0;
            end
            ST_NOTE_ON:    kind = EV_NOTE;
            ST_POLY:       kind = EV_POLY;
            ST_CC:         kind = EV_CC;
            ST_PROGRAM:    kind = EV_PROGRAM;
            ST_AFTERTOUCH: begin
                kind = EV_AFTERTOUCH;
                ctl  = 14'd0;
                val  = {7'd0, data_first};
            end
            ST_PITCH: begin
                kind = EV_PITCH;
                ctl  = 14'd0;
                val  = {data_second, data_first};
            end
            default:       kind = EV_SYSTEM;
        endcase

        skip    = msg_kind || !status_byte[7];
        is_addr = (data_first >= CC_NRPN_LSB) && (data_first <= CC_RPN_MSB);
        track   = !skip && (status_byte[7:4] == ST_CC) &&
                  (is_addr || data_first == CC_DATA_MSB || data_first == CC_DATA_LSB);

        f    = state_in.flags;
        num  = state_in.number;
        pv   = state_in.value;
        done = 1'b0;

        if (track) begin
            if ((f[FLAG_NRPN] && (data_first == CC_RPN_MSB || data_first == CC_RPN_LSB)) ||
                (!f[FLAG_NRPN] && (data_first == CC_NRPN_MSB || data_first == CC_NRPN_LSB)))
            begin
                f[FLAG_NRPN] = 1'b0;
                f[FLAG_PLO]  = 1'b0;
                f[FLAG_PHI]  = 1'b0;
            end
            if (is_addr) begin
                f[FLAG_VHI] = 1'b0;
            end
            if (data_first == CC_RPN_MSB || data_first == CC_NRPN_MSB) begin
                num[13:7]   = data_second;
                f[FLAG_PHI] = 1'b1;
                if (data_first == CC_NRPN_MSB) begin
                    f[FLAG_NRPN] = 1'b1;
                end
                if (data_first == CC_RPN_MSB && data_second == NULL_PARAM) begin
                    f[FLAG_PHI] = 1'b0;
                end
            end
            if (data_first == CC_RPN_LSB || data_first == CC_NRPN_LSB) begin
                num[6:0]    = data_second;
                f[FLAG_PLO] = 1'b1;
                if (data_first == CC_NRPN_LSB) begin
                    f[FLAG_NRPN] = 1'b1;
                end
                if (data_first == CC_RPN_LSB && data_second == NULL_PARAM) begin
                    f[FLAG_PLO] = 1'b0;
                end
            end
            if (data_first == CC_DATA_MSB && f[FLAG_PHI] && f[FLAG_PLO]) begin
                pv          = {data_second, 7'd0};
                f[FLAG_VHI] = 1'b1;
            end
            if (data_first == CC_DATA_LSB && f[FLAG_VHI]) begin
                pv[6:0]     = data_second;
                f[FLAG_VHI] = 1'b0;
                done        = 1'b1;
            end
        end

        state_out.flags  = f;
        state_out.number = num;
        state_out.value  = pv;

        plain.kind    = kind;
        plain.channel = status_byte[3:0];
        plain.control = ctl;
        plain.value   = val;
        plain.last    = 1'b1;

        if (skip) begin
            num_results = 2'd0;
            res_first   = plain;
            res_second  = plain;
        end else if (done) begin
            num_results       = 2'd2;
            res_first.kind    = f[FLAG_NRPN] ? EV_NRPN : EV_RPN;
            res_first.channel = status_byte[3:0];
            res_first.control = num;
            res_first.value   = pv;
            res_first.last    = 1'b0;
            res_second        = plain;
        end else begin
            num_results = 2'd1;
            res_first   = plain;
            res_second  = plain;
        end
    end

endmodule

[bench/midi_input_decoder_with_rpn_nrpn_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the MIDI short-message decoder with RPN/NRPN tracking.
// Drives directed and random messages with random idling and checks every result.
// Depends on mrd_pkg and midi_input_decoder_with_rpn_nrpn_top.
module midi_input_decoder_with_rpn_nrpn_top_test;
    import mrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET = 1600;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        bit          msg_kind;
        bit [7:0]    status;
        bit [6:0]    data_first;
        bit [6:0]    data_second;
        bit          typed;
        event_kind_t want_kind;
        bit [13:0]   want_control;
        bit [13:0]   want_value;
    } msg_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_msg_kind = 1'b0;
    logic [7:0]  s_status_byte = 8'h80;
    logic [6:0]  s_data_first = 7'd0;
    logic [6:0]  s_data_second = 7'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_event_kind;
    logic [3:0]  m_midi_channel;
    logic [13:0] m_control_number;
    logic [13:0] m_raw_value;
    logic        m_last_of_run;

    chan_state_t chan_state [NUM_CHANNELS];
    result_t     pending_events [$];
    msg_t        offered_msgs [$];
    msg_t        planned_msgs [$];
    msg_t        directed_rows [$];

    bit calm = 1'b0;
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int rpn_updates = 0;
    int nrpn_updates = 0;
    int idle_cycles = 0;

    midi_input_decoder_with_rpn_nrpn_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_msg_kind       (s_msg_kind),
        .s_status_byte    (s_status_byte),
        .s_data_first     (s_data_first),
        .s_data_second    (s_data_second),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_midi_channel   (m_midi_channel),
        .m_control_number (m_control_number),
        .m_raw_value      (m_raw_value),
        .m_last_of_run    (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: mismatch on result %0d: %s", $realtime, results_seen, msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [13:0] got,
                                 input logic [13:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic bit track_controller(input bit [3:0] ch, input bit [6:0] ctl,
                                            input bit [6:0] val);
        chan_state_t st;
        logic [3:0]  f;
        bit          done;
        st = chan_state[ch];
        f = st.flags;
        done = 1'b0;
        if ((f[FLAG_NRPN] && (ctl == CC_RPN_MSB || ctl == CC_RPN_LSB))
                || (!f[FLAG_NRPN] && (ctl == CC_NRPN_MSB || ctl == CC_NRPN_LSB))) begin
            f[FLAG_NRPN] = 1'b0;
            f[FLAG_PLO] = 1'b0;
            f[FLAG_PHI] = 1'b0;
        end
        if (ctl >= CC_NRPN_LSB && ctl <= CC_RPN_MSB) begin
            f[FLAG_VHI] = 1'b0;
        end
        if (ctl == CC_RPN_MSB || ctl == CC_NRPN_MSB) begin
            st.number[13:7] = val;
            f[FLAG_PHI] = 1'b1;
            if (ctl == CC_NRPN_MSB) begin
                f[FLAG_NRPN] = 1'b1;
            end
            if (ctl == CC_RPN_MSB && val == NULL_PARAM) begin
                f[FLAG_PHI] = 1'b0;
            end
        end
        if (ctl == CC_RPN_LSB || ctl == CC_NRPN_LSB) begin
            st.number[6:0] = val;
            f[FLAG_PLO] = 1'b1;
            if (ctl == CC_NRPN_LSB) begin
                f[FLAG_NRPN] = 1'b1;
            end
            if (ctl == CC_RPN_LSB && val == NULL_PARAM) begin
                f[FLAG_PLO] = 1'b0;
            end
        end
        if (ctl == CC_DATA_MSB && f[FLAG_PHI] && f[FLAG_PLO]) begin
            st.value = {val, 7'd0};
            f[FLAG_VHI] = 1'b1;
        end
        if (ctl == CC_DATA_LSB && f[FLAG_VHI]) begin
            st.value[6:0] = val;
            f[FLAG_VHI] = 1'b0;
            done = 1'b1;
        end
        st.flags = f;
        chan_state[ch] = st;
        return done;
    endfunction

    function automatic void decode_message(input msg_t m);
        event_kind_t kind;
        bit [3:0]    ch;
        bit [13:0]   ctl;
        bit [13:0]   val;
        result_t     ev;
        if (m.msg_kind || !m.status[7]) begin
            return;
        end
        ch = m.status[3:0];
        ctl = {7'd0, m.data_first};
        val = {7'd0, m.data_second};
        case (m.status[7:4])
            ST_NOTE_OFF: begin
                kind = EV_NOTE;
                val = '0;
            end
            ST_NOTE_ON: kind = EV_NOTE;
            ST_POLY: kind = EV_POLY;
            ST_CC: kind = EV_CC;
            ST_PROGRAM: kind = EV_PROGRAM;
            ST_AFTERTOUCH: begin
                kind = EV_AFTERTOUCH;
                ctl = '0;
                val = {7'd0, m.data_first};
            end
            ST_PITCH: begin
                kind = EV_PITCH;
                ctl = '0;
                val = {m.data_second, m.data_first};
            end
            default: kind = EV_SYSTEM;
        endcase
        if (kind == EV_CC && ((m.data_first >= CC_NRPN_LSB && m.data_first <= CC_RPN_MSB)
                || m.data_first == CC_DATA_MSB || m.data_first == CC_DATA_LSB)) begin
            if (track_controller(ch, m.data_first, m.data_second)) begin
                ev.kind = chan_state[ch].flags[FLAG_NRPN] ? EV_NRPN : EV_RPN;
                ev.channel = ch;
                ev.control = chan_state[ch].number;
                ev.value = chan_state[ch].value;
                ev.last = 1'b0;
                pending_events.push_back(ev);
                if (ev.kind == EV_NRPN) begin
                    nrpn_updates++;
                end else begin
                    rpn_updates++;
                end
            end
        end
        ev.kind = kind;
        ev.channel = ch;
        ev.control = ctl;
        ev.value = val;
        ev.last = 1'b1;
        pending_events.push_back(ev);
    endfunction

    always @(posedge aclk) begin
        result_t want;
        msg_t    taken;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = pending_events.pop_front();
                    compare_field("event_kind", 14'(m_event_kind), 14'(want.kind));
                    compare_field("midi_channel", 14'(m_midi_channel), 14'(want.channel));
                    compare_field("control_number", m_control_number, want.control);
                    compare_field("raw_value", m_raw_value, want.value);
                    compare_field("last_of_run", 14'(m_last_of_run), 14'(want.last));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                taken = offered_msgs.pop_front();
                // Hand-typed rows are never tracked controllers, so channel state stays put.
                if (taken.typed) begin
                    want.kind = taken.want_kind;
                    want.channel = taken.status[3:0];
                    want.control = taken.want_control;
                    want.value = taken.want_value;
                    want.last = 1'b1;
                    pending_events.push_back(want);
                end else begin
                    decode_message(taken);
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("midi_input_decoder_with_rpn_nrpn_top_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic msg_t make_msg(input bit k, input bit [7:0] st, input bit [6:0] a,
                                      input bit [6:0] b);
        msg_t m;
        m = '0;
        m.msg_kind = k;
        m.status = st;
        m.data_first = a;
        m.data_second = b;
        m.want_kind = EV_NOTE;
        return m;
    endfunction

    function automatic msg_t typed_msg(input bit [7:0] st, input bit [6:0] a, input bit [6:0] b,
                                       input event_kind_t k, input bit [13:0] ctl,
                                       input bit [13:0] val);
        msg_t m;
        m = make_msg(1'b0, st, a, b);
        m.typed = 1'b1;
        m.want_kind = k;
        m.want_control = ctl;
        m.want_value = val;
        return m;
    endfunction

    function automatic msg_t cc_msg(input bit [3:0] ch, input bit [6:0] ctl, input bit [6:0] val);
        return make_msg(1'b0, {ST_CC, ch}, ctl, val);
    endfunction

    function automatic bit [6:0] data_byte();
        case ($urandom_range(0, 7))
            0: return 7'd127;
            1: return 7'd0;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic bit [6:0] tracked_ctl();
        case ($urandom_range(0, 5))
            0: return CC_RPN_MSB;
            1: return CC_RPN_LSB;
            2: return CC_NRPN_MSB;
            3: return CC_NRPN_LSB;
            4: return CC_DATA_MSB;
            default: return CC_DATA_LSB;
        endcase
    endfunction

    task automatic send_msg(input msg_t m);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        offered_msgs.push_back(m);
        s_valid <= 1'b1;
        s_msg_kind <= m.msg_kind;
        s_status_byte <= m.status;
        s_data_first <= m.data_first;
        s_data_second <= m.data_second;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!m.msg_kind && m.status[7]) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Mostly well-formed parameter sequences; the rest is loose controllers and noise.
    task automatic plan_burst();
        int       r;
        int       pairs;
        bit [3:0] ch;
        bit       nrpn;
        bit [6:0] msb;
        bit [6:0] lsb;
        r = $urandom_range(0, 99);
        ch = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        if (r < 8) begin
            planned_msgs.push_back(make_msg(1'($urandom_range(0, 1)),
                                            8'($urandom_range(0, 255)),
                                            7'($urandom_range(0, 127)),
                                            7'($urandom_range(0, 127))));
        end else if (r < 28) begin
            planned_msgs.push_back(make_msg(1'b0, 8'($urandom_range(128, 255)), data_byte(),
                                            data_byte()));
        end else if (r < 40) begin
            planned_msgs.push_back(cc_msg(ch, tracked_ctl(), data_byte()));
        end else begin
            nrpn = 1'($urandom_range(0, 1));
            msb = nrpn ? CC_NRPN_MSB : CC_RPN_MSB;
            lsb = nrpn ? CC_NRPN_LSB : CC_RPN_LSB;
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    planned_msgs.push_back(cc_msg(ch, lsb, data_byte()));
                    planned_msgs.push_back(cc_msg(ch, msb, data_byte()));
                end else begin
                    planned_msgs.push_back(cc_msg(ch, msb, data_byte()));
                    planned_msgs.push_back(cc_msg(ch, lsb, data_byte()));
                end
            end
            pairs = $urandom_range(1, 3);
            repeat (pairs) begin
                if ($urandom_range(0, 7) == 0) begin
                    planned_msgs.push_back(make_msg(1'b0, {4'($urandom_range(8, 15)), ch},
                                                    data_byte(), data_byte()));
                end
                if ($urandom_range(0, 5) != 0) begin
                    planned_msgs.push_back(cc_msg(ch, CC_DATA_MSB, data_byte()));
                end
                if ($urandom_range(0, 5) != 0) begin
                    planned_msgs.push_back(cc_msg(ch, CC_DATA_LSB, data_byte()));
                end
            end
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_state[i] = '0;
        end

        directed_rows.push_back(make_msg(1'b1, 8'h90, 7'd60, 7'd100));
        directed_rows.push_back(make_msg(1'b0, 8'h7F, 7'd127, 7'd127));
        directed_rows.push_back(typed_msg(8'h80, 7'd127, 7'd127, EV_NOTE, 14'd127, 14'd0));
        directed_rows.push_back(typed_msg(8'h9F, 7'd127, 7'd127, EV_NOTE, 14'd127, 14'd127));
        directed_rows.push_back(typed_msg(8'hA3, 7'd0, 7'd0, EV_POLY, 14'd0, 14'd0));
        directed_rows.push_back(typed_msg(8'hC5, 7'd5, 7'd99, EV_PROGRAM, 14'd5, 14'd99));
        directed_rows.push_back(typed_msg(8'hD7, 7'd100, 7'd3, EV_AFTERTOUCH, 14'd0, 14'd100));
        directed_rows.push_back(typed_msg(8'hE2, 7'd127, 7'd127, EV_PITCH, 14'd0, 14'd16383));
        directed_rows.push_back(typed_msg(8'hF0, 7'd1, 7'd2, EV_SYSTEM, 14'd1, 14'd2));
        directed_rows.push_back(typed_msg(8'hFF, 7'd127, 7'd127, EV_SYSTEM, 14'd127, 14'd127));
        directed_rows.push_back(cc_msg(4'd1, CC_RPN_MSB, 7'd0));
        directed_rows.push_back(cc_msg(4'd1, CC_RPN_LSB, 7'd0));
        directed_rows.push_back(cc_msg(4'd1, CC_DATA_MSB, 7'd127));
        directed_rows.push_back(cc_msg(4'd1, CC_DATA_LSB, 7'd127));
        directed_rows.push_back(cc_msg(4'd2, CC_NRPN_MSB, 7'd127));
        directed_rows.push_back(cc_msg(4'd2, CC_NRPN_LSB, 7'd127));
        directed_rows.push_back(cc_msg(4'd2, CC_DATA_MSB, 7'd0));
        directed_rows.push_back(cc_msg(4'd2, CC_DATA_LSB, 7'd1));
        directed_rows.push_back(cc_msg(4'd2, CC_DATA_MSB, 7'd3));
        directed_rows.push_back(cc_msg(4'd2, CC_RPN_MSB, 7'd5));
        directed_rows.push_back(cc_msg(4'd2, CC_DATA_LSB, 7'd9));
        directed_rows.push_back(cc_msg(4'd3, CC_RPN_MSB, NULL_PARAM));
        directed_rows.push_back(cc_msg(4'd3, CC_RPN_LSB, NULL_PARAM));
        directed_rows.push_back(cc_msg(4'd3, CC_DATA_MSB, 7'd5));
        directed_rows.push_back(cc_msg(4'd3, CC_DATA_LSB, 7'd1));
        directed_rows.push_back(make_msg(1'b1, 8'hB4, CC_NRPN_MSB, 7'd1));
        directed_rows.push_back(cc_msg(4'd4, CC_DATA_MSB, 7'd2));
        directed_rows.push_back(cc_msg(4'd4, CC_DATA_LSB, 7'd3));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_msg(directed_rows[i]);
        end
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                calm = !calm;
            end
            plan_burst();
            while (planned_msgs.size() != 0) begin
                send_msg(planned_msgs.pop_front());
            end
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d decoded messages and %0d checked results,", items_sent,
                 results_seen);
        $display("including %0d RPN and %0d NRPN parameter updates; %0d mismatches.",
                 rpn_updates, nrpn_updates, error_count);
        if (error_count == 0) begin
            $display("midi_input_decoder_with_rpn_nrpn_top_test: PASS");
        end else begin
            $display("midi_input_decoder_with_rpn_nrpn_top_test: FAIL");
        end
        $finish;
    end

endmodule
